[rtl/osm_pkg.sv]
`timescale 1ns / 1ps

package osm_pkg;

  // store geometry
  localparam int CAPACITY = 1024;
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // reduction tree: cells are gathered in groups, groups are combined after
  localparam int GROUP    = 32;
  localparam int GIDX_W   = $clog2(GROUP);
  localparam int NGROUP   = (CAPACITY + GROUP - 1) / GROUP;

  localparam int VAL_W    = 32;
  localparam int OUT_CNT_W = 11;

  typedef enum logic [2:0] {
    KIND_INSERT = 3'd0,
    KIND_ERASE  = 3'd1,
    KIND_RANK   = 3'd2,
    KIND_KTH    = 3'd3,
    KIND_PRED   = 3'd4,
    KIND_SUCC   = 3'd5
  } osm_kind_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_FULL  = 2'd2
  } osm_status_e;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [VAL_W-1:0] operand;
  } osm_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [1:0]              status;
    logic [OUT_CNT_W-1:0]    entry_count;
  } osm_rsp_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic                    ers_en;
    logic [2:0]              kind;
    logic signed [VAL_W-1:0] operand;
    logic [CNT_W-1:0]        count;
    logic                    k_ok;
    logic [IDX_W-1:0]        kidx;
  } osm_ctrl_t;

  // registered result of one group of cells
  typedef struct packed {
    logic                    hit;
    logic [GIDX_W-1:0]       lidx;
    logic signed [VAL_W-1:0] val;
  } osm_grp_t;

endpackage

[rtl/osm_cell.sv]
`timescale 1ns / 1ps

module osm_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [osm_pkg::IDX_W-1:0]        idx_i,
  input  osm_pkg::osm_ctrl_t               ctrl_i,
  input  logic signed [osm_pkg::VAL_W-1:0] prev_val_i,
  input  logic                             prev_lt_i,
  input  logic                             prev_le_i,
  input  logic signed [osm_pkg::VAL_W-1:0] next_val_i,
  input  logic                             next_lt_i,
  output logic signed [osm_pkg::VAL_W-1:0] val_o,
  output logic                             lt_o,
  output logic                             le_o,
  output logic                             mark_o
);
  import osm_pkg::*;

  logic signed [VAL_W-1:0] val_q;
  logic                    lt_q, le_q, eq_q;
  logic                    filled;
  logic                    first_ge;

  assign filled   = CNT_W'(idx_i) < ctrl_i.count;
  assign first_ge = !lt_q && prev_lt_i;

  // compare flags against the operand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      le_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      lt_q <= filled && (val_q <  ctrl_i.operand);
      le_q <= filled && (val_q <= ctrl_i.operand);
      eq_q <= filled && (val_q == ctrl_i.operand);
    end
  end

  // shift right on insert, left on erase
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en && !le_q) begin
      val_q <= prev_le_i ? ctrl_i.operand : prev_val_i;
    end else if (ctrl_i.ers_en && !lt_q) begin
      val_q <= next_val_i;
    end
  end

  // select this cell for the reduction tree
  always_comb begin
    unique case (ctrl_i.kind)
      KIND_ERASE: mark_o = first_ge && eq_q;
      KIND_RANK:  mark_o = first_ge;
      KIND_KTH:   mark_o = ctrl_i.k_ok && (idx_i == ctrl_i.kidx);
      KIND_PRED:  mark_o = lt_q && !next_lt_i;
      KIND_SUCC:  mark_o = !le_q && filled && prev_le_i;
      default:    mark_o = 1'b0;
    endcase
  end

  assign val_o = val_q;
  assign lt_o  = lt_q;
  assign le_o  = le_q;

endmodule

[rtl/osm_group.sv]
`timescale 1ns / 1ps

module osm_group (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             mark_i [osm_pkg::GROUP],
  input  logic signed [osm_pkg::VAL_W-1:0] val_i  [osm_pkg::GROUP],
  output osm_pkg::osm_grp_t                grp_o
);
  import osm_pkg::*;

  osm_grp_t grp_d, grp_q;

  // at most one mark is set, so OR gathers index and value
  always_comb begin
    grp_d = '0;
    for (int j = 0; j < GROUP; j++) begin
      if (mark_i[j]) begin
        grp_d.hit  = 1'b1;
        grp_d.lidx = grp_d.lidx | GIDX_W'(j);
        grp_d.val  = grp_d.val | val_i[j];
      end
    end
  end

  // register the group result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q <= '0;
    end else begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

[rtl/order_statistic_multiset.sv]
`timescale 1ns / 1ps

// Ordered multiset of signed 32-bit values, held sorted in a row of cells.
// Input channel in_valid_i / in_stall_o / in_data_i carries one request
// (req_type, operand); output channel out_valid_o / out_stall_i / out_data_o
// carries one response (result_value, status, entry_count) per request.
// A transaction moves at a rising edge with valid high and stall low.
// A request goes through compare, group reduction, group combine and update
// in turn, one request at a time: a new request is taken only once the last
// one has finished its update.
// Every cell compares against the operand in parallel; insert and erase
// shift the tail of the row, from the operand's place on, by one position in the update cycle.
// Reset empties the store (count zero), clears the response valid flag and
// returns the sequencer to idle; the stored values themselves are not
// cleared and are never read while empty.
// If out_stall_i holds a response, the next request waits in its update
// step and in_stall_o stays high until the response is taken.

module order_statistic_multiset (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  osm_pkg::osm_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output osm_pkg::osm_rsp_t out_data_o
);
  import osm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_FIN,
    ST_DONE
  } state_e;

  state_e                  state_q;
  osm_req_t                req_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    out_valid_q;
  osm_rsp_t                out_q, out_d;
  logic                    hit_q, hit_d;
  logic [CNT_W-1:0]        pidx_q, pidx_d;
  logic signed [VAL_W-1:0] rval_q, rval_d;
  logic                    done_fire;
  logic                    full;
  osm_ctrl_t               ctrl;

  logic signed [VAL_W-1:0] cval   [CAPACITY];
  logic                    clt    [CAPACITY];
  logic                    cle    [CAPACITY];
  logic                    cmark  [CAPACITY];
  logic                    pmark  [NGROUP*GROUP];
  logic signed [VAL_W-1:0] pval   [NGROUP*GROUP];
  osm_grp_t                grp    [NGROUP];
  logic [NGROUP-1:0]       grp_hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign done_fire  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign full       = (count_q >= CNT_W'(CAPACITY));

  // broadcast control to the row
  always_comb begin
    ctrl         = '0;
    ctrl.cmp_en  = (state_q == ST_CMP);
    ctrl.ins_en  = done_fire && (req_q.req_type == KIND_INSERT) && !full;
    ctrl.ers_en  = done_fire && (req_q.req_type == KIND_ERASE) && hit_q;
    ctrl.kind    = req_q.req_type;
    ctrl.operand = req_q.operand;
    ctrl.count   = count_q;
    ctrl.k_ok    = (req_q.operand > 0) &&
                   (req_q.operand <= $signed({{(VAL_W-CNT_W){1'b0}}, count_q}));
    ctrl.kidx    = IDX_W'(req_q.operand - 1);
  end

  // row of cells with neighbor links
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] pv, nv;
    logic                    plt, ple, nlt;
    if (i == 0) begin : g_first
      assign pv  = cval[i];
      assign plt = 1'b1;
      assign ple = 1'b1;
    end else begin : g_mid
      assign pv  = cval[i-1];
      assign plt = clt[i-1];
      assign ple = cle[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nv  = cval[i];
      assign nlt = 1'b0;
    end else begin : g_body
      assign nv  = cval[i+1];
      assign nlt = clt[i+1];
    end
    osm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(i)),
      .ctrl_i     (ctrl),
      .prev_val_i (pv),
      .prev_lt_i  (plt),
      .prev_le_i  (ple),
      .next_val_i (nv),
      .next_lt_i  (nlt),
      .val_o      (cval[i]),
      .lt_o       (clt[i]),
      .le_o       (cle[i]),
      .mark_o     (cmark[i])
    );
  end

  // pad the row up to whole groups
  for (genvar j = 0; j < NGROUP * GROUP; j++) begin : g_pad
    if (j < CAPACITY) begin : g_real
      assign pmark[j] = cmark[j];
      assign pval[j]  = cval[j];
    end else begin : g_zero
      assign pmark[j] = 1'b0;
      assign pval[j]  = '0;
    end
  end

  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    osm_group u_group (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mark_i (pmark[g*GROUP +: GROUP]),
      .val_i  (pval[g*GROUP +: GROUP]),
      .grp_o  (grp[g])
    );
    assign grp_hit[g] = grp[g].hit;
  end

  // combine the group results
  always_comb begin
    hit_d  = 1'b0;
    pidx_d = '0;
    rval_d = '0;
    for (int g = 0; g < NGROUP; g++) begin
      if (grp[g].hit) begin
        hit_d  = 1'b1;
        pidx_d = pidx_d | (CNT_W'(g * GROUP) + CNT_W'(grp[g].lidx));
        rval_d = rval_d | grp[g].val;
      end
    end
  end

  // build the response and the new count
  always_comb begin
    out_d              = '0;
    count_d            = count_q;
    out_d.status       = STAT_OK;
    out_d.result_value = '0;
    unique case (req_q.req_type)
      KIND_INSERT: begin
        if (full) begin
          out_d.status = STAT_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      KIND_ERASE: begin
        if (hit_q) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      KIND_RANK: begin
        out_d.result_value = hit_q ? VAL_W'(pidx_q) + VAL_W'(1)
                                   : VAL_W'(CAPACITY) + VAL_W'(1);
      end
      KIND_KTH, KIND_PRED, KIND_SUCC: begin
        if (hit_q) begin
          out_d.result_value = rval_q;
        end else begin
          out_d.status = STAT_NONE;
        end
      end
      default: begin
        out_d.status = STAT_OK;
      end
    endcase
    out_d.entry_count = OUT_CNT_W'(count_d);
  end

  // sequencer, count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // raise on a new response, drop once the held one is taken
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: if (in_valid_i) state_q <= ST_CMP;
        ST_CMP:  state_q <= ST_GRP;
        ST_GRP:  state_q <= ST_FIN;
        ST_FIN:  state_q <= ST_DONE;
        ST_DONE: begin
          if (done_fire) begin
            state_q <= ST_IDLE;
            count_q <= count_d;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_FIN) begin
      hit_q  <= hit_d;
      pidx_q <= pidx_d;
      rval_q <= rval_d;
    end
    if (done_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_onehot_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |-> $onehot0(grp_hit))
    else $error("more than one group selected");

  a_rise_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("response raised outside the update step");

  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && req_q.req_type == KIND_INSERT && !full)
      |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the store");

endmodule
